// ===== design/pps_pkg.sv =====
// Package: shared types, widths and codes of the playback phase sequencer.
`timescale 1ns / 1ps
package pps_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = FRAC_BITS + 1;
  localparam int MS_W       = 16;
  localparam int RATE_W     = 24;
  localparam int SPEED_W    = 16;
  localparam int PROD1_W    = MS_W + SPEED_W;
  localparam int PROD_W     = PROD1_W + RATE_W;
  localparam int PROD_FRAC  = 36;
  localparam int D_W        = PROD_W - (PROD_FRAC - FRAC_BITS);
  localparam int EXT_W      = D_W + 1;
  localparam int OP_W       = 3;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [POS_W-1:0]   ONE_POS   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(40960);
  localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(4096);

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_PLAY   = 3'd1;
  localparam logic [OP_W-1:0] OP_PAUSE  = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
  localparam logic [OP_W-1:0] OP_SETPOS = 3'd4;
  localparam logic [OP_W-1:0] OP_SELECT = 3'd5;

  localparam logic [MODE_W-1:0] MODE_STATIC   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REVERSE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PINGPONG = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RPINGPONG = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               loop_enable;
    logic [RATE_W-1:0]  base_rate;
    logic [SPEED_W-1:0] speed_scale;
    logic               has_action;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] phase;
    logic             forward;
    logic             playing;
    logic             paused;
    logic             ev_play;
    logic             ev_start;
    logic             ev_end;
    logic             ev_change;
    logic             ev_stop;
    logic             ev_pause_on;
    logic             ev_pause_off;
  } result_t;

endpackage

// ===== design/pps_cfg.sv =====
// Configuration register file of the playback phase sequencer.
`timescale 1ns / 1ps
module pps_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pps_pkg::cfg_t                  cfg_o
);
  import pps_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= MODE_NORMAL;
      cfg_q.loop_enable <= 1'b0;
      cfg_q.base_rate   <= '0;
      cfg_q.speed_scale <= SPEED_RST;
      cfg_q.has_action  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:   cfg_q.mode        <= cfg_data_i[MODE_W-1:0];
        CFG_LOOP:   cfg_q.loop_enable <= cfg_data_i[0];
        CFG_RATE:   cfg_q.base_rate   <= cfg_data_i[RATE_W-1:0];
        CFG_SPEED:  cfg_q.speed_scale <= cfg_data_i[SPEED_W-1:0];
        CFG_ACTION: cfg_q.has_action  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/pps_ctrl.sv =====
// Controller: sequences capture, two multiply steps and the state update.
`timescale 1ns / 1ps
module pps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pps_pkg::cmd_t cmd_o
);
  import pps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_UPD
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.load   = in_valid_i && (state_q == ST_IDLE);
    cmd_o.mul1   = (state_q == ST_MUL1);
    cmd_o.mul2   = (state_q == ST_MUL2);
    cmd_o.commit = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_MUL1;
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_UPD;
        ST_UPD:  if (cmd_o.commit) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/pps_dp.sv =====
// Datapath: phase advance multiply, mode logic, playback state and result register.
`timescale 1ns / 1ps
module pps_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pps_pkg::cmd_t               cmd_i,
  input  pps_pkg::cfg_t               cfg_i,
  input  logic [pps_pkg::OP_W-1:0]    op_i,
  input  logic [pps_pkg::MS_W-1:0]    elapsed_ms_i,
  input  logic [pps_pkg::POS_W-1:0]   new_position_i,
  output pps_pkg::result_t            res_o
);
  import pps_pkg::*;

  logic [OP_W-1:0]    op_q;
  logic [MS_W-1:0]    ms_q;
  logic [POS_W-1:0]   npos_q;
  logic [PROD1_W-1:0] prod1_q;
  logic [PROD_W-1:0]  prod_q;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               fwd_q, fwd_d;
  logic               play_q, play_d;
  logic               pause_q, pause_d;
  result_t            res_q, res_d;

  logic [SPEED_W-1:0] speed_sat;
  logic [D_W-1:0]     d_val;
  logic [EXT_W-1:0]   p_ext, d_ext, sum, diff, one_ext;
  logic [POS_W-1:0]   sum_frac, diff_frac, sum_low, p_minus_d;
  logic               sum_over, d_ge_p, d_gt_p;
  logic               rew_back;
  logic [POS_W-1:0]   rew_pos;
  logic               tick_on, finished;

  assign speed_sat = (cfg_i.speed_scale > SPEED_MAX) ? SPEED_MAX : cfg_i.speed_scale;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      ms_q   <= elapsed_ms_i;
      npos_q <= new_position_i;
    end
    if (cmd_i.mul1) prod1_q <= ms_q * speed_sat;
    if (cmd_i.mul2) prod_q  <= prod1_q * cfg_i.base_rate;
    if (cmd_i.commit) res_q <= res_d;
  end

  always_comb begin
    d_val     = prod_q[PROD_W-1:PROD_FRAC-FRAC_BITS];
    p_ext     = EXT_W'(pos_q);
    d_ext     = EXT_W'(d_val);
    one_ext   = EXT_W'(ONE_POS);
    sum       = p_ext + d_ext;
    diff      = d_ext - p_ext;
    sum_over  = (sum >= one_ext);
    d_ge_p    = (d_ext >= p_ext);
    d_gt_p    = (d_ext > p_ext);
    sum_frac  = {1'b0, sum[FRAC_BITS-1:0]};
    diff_frac = {1'b0, diff[FRAC_BITS-1:0]};
    sum_low   = sum[POS_W-1:0];
    p_minus_d = pos_q - d_val[POS_W-1:0];
    rew_back  = cfg_i.has_action &&
                ((cfg_i.mode == MODE_REVERSE) || (cfg_i.mode == MODE_RPINGPONG));
    rew_pos   = rew_back ? ONE_POS : '0;
    tick_on   = cfg_i.has_action && play_q && !pause_q &&
                (cfg_i.mode >= MODE_NORMAL) && (cfg_i.mode <= MODE_RPINGPONG);
  end

  always_comb begin
    pos_d    = pos_q;
    fwd_d    = fwd_q;
    play_d   = play_q;
    pause_d  = pause_q;
    finished = 1'b0;
    res_d    = '0;
    unique case (op_q)
      OP_TICK: begin
        if (tick_on) begin
          unique case (cfg_i.mode)
            MODE_NORMAL: begin
              if (sum_over) begin
                res_d.ev_end = 1'b1;
                if (cfg_i.loop_enable) begin
                  pos_d = sum_frac;
                  res_d.ev_start = 1'b1;
                end else finished = 1'b1;
              end else pos_d = sum_low;
            end
            MODE_REVERSE: begin
              if (d_ge_p) begin
                res_d.ev_end = 1'b1;
                if (cfg_i.loop_enable) begin
                  pos_d = ONE_POS - diff_frac;
                  res_d.ev_start = 1'b1;
                end else finished = 1'b1;
              end else pos_d = p_minus_d;
            end
            MODE_PINGPONG: begin
              if (fwd_q) begin
                if (sum_over) begin
                  pos_d = ONE_POS - sum_frac;
                  fwd_d = 1'b0;
                  res_d.ev_change = 1'b1;
                end else pos_d = sum_low;
              end else if (d_gt_p) begin
                res_d.ev_end = 1'b1;
                if (cfg_i.loop_enable) begin
                  pos_d = diff_frac;
                  fwd_d = 1'b1;
                  res_d.ev_start = 1'b1;
                end else finished = 1'b1;
              end else pos_d = p_minus_d;
            end
            default: begin
              if (!fwd_q) begin
                if (d_gt_p) begin
                  pos_d = diff_frac;
                  fwd_d = 1'b1;
                  res_d.ev_change = 1'b1;
                end else pos_d = p_minus_d;
              end else if (sum_over) begin
                res_d.ev_end = 1'b1;
                if (cfg_i.loop_enable) begin
                  pos_d = ONE_POS - sum_frac;
                  fwd_d = 1'b0;
                  res_d.ev_start = 1'b1;
                end else finished = 1'b1;
              end else pos_d = sum_low;
            end
          endcase
          if (finished) begin
            play_d = 1'b0;
            pause_d = 1'b0;
            res_d.ev_stop = 1'b1;
            pos_d = rew_pos;
            fwd_d = !rew_back;
          end
        end
      end
      OP_PLAY: begin
        if (cfg_i.has_action && !(play_q && !pause_q)) begin
          play_d = 1'b1;
          pause_d = 1'b0;
          if (pause_q) begin
            res_d.ev_pause_off = 1'b1;
          end else begin
            res_d.ev_play  = 1'b1;
            res_d.ev_start = 1'b1;
          end
        end
      end
      OP_PAUSE: begin
        pause_d = 1'b1;
        res_d.ev_pause_on = 1'b1;
      end
      OP_STOP: begin
        pos_d = rew_pos;
        fwd_d = !rew_back;
        play_d = 1'b0;
        pause_d = 1'b0;
        res_d.ev_stop = 1'b1;
      end
      OP_SETPOS: begin
        pos_d = (npos_q > ONE_POS) ? ONE_POS : npos_q;
      end
      OP_SELECT: begin
        pos_d = rew_pos;
        fwd_d = !rew_back;
        play_d = 1'b0;
        pause_d = 1'b0;
      end
      default: ;
    endcase
    res_d.phase   = pos_d;
    res_d.forward = fwd_d;
    res_d.playing = play_d;
    res_d.paused  = pause_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fwd_q   <= 1'b1;
      play_q  <= 1'b0;
      pause_q <= 1'b0;
    end else if (cmd_i.commit) begin
      pos_q   <= pos_d;
      fwd_q   <= fwd_d;
      play_q  <= play_d;
      pause_q <= pause_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/playback_phase_sequencer.sv =====
// Playback phase sequencer (top level).
// Input channel (in_valid_i / in_ready_o) carries one op per transaction: tick,
// play, pause, stop, set position or select. Each accepted transaction yields
// exactly one result transaction on out_valid_o / out_ready_i with the phase
// (Q1.16), direction, play and pause flags and the one-shot event bits.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready and
// writes register cfg_index_i with cfg_data_i; write it only while idle.
// Each item passes through capture, two registered multiply steps
// (elapsed_ms x speed, then x base_rate) and the update; a new item is
// accepted only after the current one has been committed.
// A new item is accepted while a result waits; if the result register is
// still occupied when the next update is due, the update holds until the
// receiver takes the pending result, and input stays blocked meanwhile.
// Reset: phase 0, forward, stopped, not paused; mode normal, loop off,
// base rate 0, speed 1.0, no action loaded; no result pending.
`timescale 1ns / 1ps
module playback_phase_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pps_pkg::OP_W-1:0]       op_i,
  input  logic [pps_pkg::MS_W-1:0]       elapsed_ms_i,
  input  logic [pps_pkg::POS_W-1:0]      new_position_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pps_pkg::POS_W-1:0]      phase_o,
  output logic                           forward_o,
  output logic                           playing_o,
  output logic                           paused_o,
  output logic                           ev_play_o,
  output logic                           ev_start_o,
  output logic                           ev_end_o,
  output logic                           ev_change_o,
  output logic                           ev_stop_o,
  output logic                           ev_pause_on_o,
  output logic                           ev_pause_off_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pps_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  result_t res;

  assign cfg_ready_o = 1'b1;

  pps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  pps_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .op_i           (op_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .new_position_i (new_position_i),
    .res_o          (res)
  );

  assign phase_o        = res.phase;
  assign forward_o      = res.forward;
  assign playing_o      = res.playing;
  assign paused_o       = res.paused;
  assign ev_play_o      = res.ev_play;
  assign ev_start_o     = res.ev_start;
  assign ev_end_o       = res.ev_end;
  assign ev_change_o    = res.ev_change;
  assign ev_stop_o      = res.ev_stop;
  assign ev_pause_on_o  = res.ev_pause_on;
  assign ev_pause_off_o = res.ev_pause_off;

endmodule

// ===== tb/pps_phase_checker.sv =====
// Checker: predicts each result of the phase sequencer and compares it on the output channel.
`timescale 1ns / 1ps
module pps_phase_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [pps_pkg::OP_W-1:0]       op_i,
  input  logic [pps_pkg::MS_W-1:0]       elapsed_ms_i,
  input  logic [pps_pkg::POS_W-1:0]      new_position_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  pps_pkg::result_t               report_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    faults_o,
  output int unsigned                    awaiting_o
);
  import pps_pkg::*;

  localparam logic [63:0] UNIT      = 64'(ONE_POS);
  localparam logic [63:0] FRAC_MASK = UNIT - 64'd1;

  cfg_t             settings;
  logic [POS_W-1:0] pos;
  logic             fwd;
  logic             playing;
  logic             paused;
  result_t          reports_q[$];
  int unsigned      faults;

  assign faults_o = faults;

  function automatic void rewind_phase();
    pos = '0;
    fwd = 1'b1;
    if (settings.has_action &&
        (settings.mode == MODE_REVERSE || settings.mode == MODE_RPINGPONG)) begin
      pos = ONE_POS;
      fwd = 1'b0;
    end
  endfunction

  function automatic result_t predict(input logic [OP_W-1:0]  op,
                                      input logic [MS_W-1:0]  ms,
                                      input logic [POS_W-1:0] npos);
    result_t    r;
    logic [63:0] sc;
    logic [63:0] d;
    logic [63:0] p;
    logic        finished;
    r = '0;
    finished = 1'b0;
    case (op)
      OP_TICK: begin
        if (settings.has_action && playing && !paused &&
            settings.mode >= MODE_NORMAL && settings.mode <= MODE_RPINGPONG) begin
          sc = (settings.speed_scale > SPEED_MAX) ? 64'(SPEED_MAX) : 64'(settings.speed_scale);
          d = (64'(ms) * 64'(settings.base_rate) * sc) >> (PROD_FRAC - FRAC_BITS);
          p = 64'(pos);
          case (settings.mode)
            MODE_NORMAL: begin
              p = p + d;
              if (p >= UNIT) begin
                r.ev_end = 1'b1;
                if (settings.loop_enable) begin
                  p = p & FRAC_MASK;
                  r.ev_start = 1'b1;
                end else finished = 1'b1;
              end
            end
            MODE_REVERSE: begin
              if (d >= p) begin
                r.ev_end = 1'b1;
                if (settings.loop_enable) begin
                  p = UNIT - ((d - p) & FRAC_MASK);
                  r.ev_start = 1'b1;
                end else finished = 1'b1;
              end else p = p - d;
            end
            MODE_PINGPONG: begin
              if (fwd) begin
                p = p + d;
                if (p >= UNIT) begin
                  p = UNIT - (p & FRAC_MASK);
                  fwd = 1'b0;
                  r.ev_change = 1'b1;
                end
              end else if (d > p) begin
                r.ev_end = 1'b1;
                if (settings.loop_enable) begin
                  p = (d - p) & FRAC_MASK;
                  fwd = 1'b1;
                  r.ev_start = 1'b1;
                end else finished = 1'b1;
              end else p = p - d;
            end
            MODE_RPINGPONG: begin
              if (!fwd) begin
                if (d > p) begin
                  p = (d - p) & FRAC_MASK;
                  fwd = 1'b1;
                  r.ev_change = 1'b1;
                end else p = p - d;
              end else begin
                p = p + d;
                if (p >= UNIT) begin
                  r.ev_end = 1'b1;
                  if (settings.loop_enable) begin
                    p = UNIT - (p & FRAC_MASK);
                    fwd = 1'b0;
                    r.ev_start = 1'b1;
                  end else finished = 1'b1;
                end
              end
            end
            default: ;
          endcase
          pos = (p > UNIT) ? ONE_POS : POS_W'(p);
          if (finished) begin
            playing = 1'b0;
            paused = 1'b0;
            r.ev_stop = 1'b1;
            rewind_phase();
          end
        end
      end
      OP_PLAY: begin
        if (settings.has_action && !(playing && !paused)) begin
          playing = 1'b1;
          if (paused) r.ev_pause_off = 1'b1;
          else begin
            r.ev_play = 1'b1;
            r.ev_start = 1'b1;
          end
          paused = 1'b0;
        end
      end
      OP_PAUSE: begin
        paused = 1'b1;
        r.ev_pause_on = 1'b1;
      end
      OP_STOP: begin
        rewind_phase();
        playing = 1'b0;
        paused = 1'b0;
        r.ev_stop = 1'b1;
      end
      OP_SETPOS: pos = (npos > ONE_POS) ? ONE_POS : npos;
      OP_SELECT: begin
        playing = 1'b0;
        paused = 1'b0;
        rewind_phase();
      end
      default: ;
    endcase
    r.phase = pos;
    r.forward = fwd;
    r.playing = playing;
    r.paused = paused;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      faults++;
      if (faults <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      settings.mode = MODE_NORMAL;
      settings.loop_enable = 1'b0;
      settings.base_rate = '0;
      settings.speed_scale = SPEED_RST;
      settings.has_action = 1'b0;
      pos = '0;
      fwd = 1'b1;
      playing = 1'b0;
      paused = 1'b0;
      reports_q.delete();
      awaiting_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (reports_q.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("%0t: result with nothing expected, phase %0h", $realtime,
                     report_i.phase);
        end else begin
          want = reports_q.pop_front();
          check_field("phase", 32'(want.phase), 32'(report_i.phase));
          check_field("forward", 32'(want.forward), 32'(report_i.forward));
          check_field("playing", 32'(want.playing), 32'(report_i.playing));
          check_field("paused", 32'(want.paused), 32'(report_i.paused));
          check_field("ev_play", 32'(want.ev_play), 32'(report_i.ev_play));
          check_field("ev_start", 32'(want.ev_start), 32'(report_i.ev_start));
          check_field("ev_end", 32'(want.ev_end), 32'(report_i.ev_end));
          check_field("ev_change", 32'(want.ev_change), 32'(report_i.ev_change));
          check_field("ev_stop", 32'(want.ev_stop), 32'(report_i.ev_stop));
          check_field("ev_pause_on", 32'(want.ev_pause_on), 32'(report_i.ev_pause_on));
          check_field("ev_pause_off", 32'(want.ev_pause_off), 32'(report_i.ev_pause_off));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MODE:   settings.mode = cfg_data_i[MODE_W-1:0];
          CFG_LOOP:   settings.loop_enable = cfg_data_i[0];
          CFG_RATE:   settings.base_rate = cfg_data_i[RATE_W-1:0];
          CFG_SPEED:  settings.speed_scale = cfg_data_i[SPEED_W-1:0];
          CFG_ACTION: settings.has_action = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        reports_q.push_back(predict(op_i, elapsed_ms_i, new_position_i));
      awaiting_o <= reports_q.size();
    end
  end

endmodule

// ===== tb/playback_phase_sequencer_tb.sv =====
// Testbench top: drives ops and configuration into the phase sequencer and gives the verdict.
`timescale 1ns / 1ps
module playback_phase_sequencer_tb;
  import pps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [OP_W-1:0]   OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0]   OP_SPARE_HI = 3'd7;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [OP_W-1:0]       op_i;
  logic [MS_W-1:0]       elapsed_ms_i;
  logic [POS_W-1:0]      new_position_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [POS_W-1:0]      phase_o;
  logic                  forward_o;
  logic                  playing_o;
  logic                  paused_o;
  logic                  ev_play_o;
  logic                  ev_start_o;
  logic                  ev_end_o;
  logic                  ev_change_o;
  logic                  ev_stop_o;
  logic                  ev_pause_on_o;
  logic                  ev_pause_off_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned faults;
  int unsigned awaiting;
  int unsigned cycle_count = 0;
  logic        calm = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  playback_phase_sequencer dut (.*);

  pps_phase_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .op_i           (op_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .new_position_i (new_position_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .report_i       ({phase_o, forward_o, playing_o, paused_o, ev_play_o, ev_start_o,
                      ev_end_o, ev_change_o, ev_stop_o, ev_pause_on_o, ev_pause_off_o}),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .faults_o       (faults),
    .awaiting_o     (awaiting)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random back-pressure, two long hold-offs to fill the block
  initial begin
    int          gap;
    int unsigned taken;
    out_ready_i = 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == 120 || taken == 420) begin
        out_ready_i <= 1'b0;
        repeat (160) @(posedge clk_i);
      end
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [MS_W-1:0] ms,
                           input logic [POS_W-1:0] npos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    elapsed_ms_i <= ms;
    new_position_i <= npos;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaiting != 0);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic loop_on,
                           input logic [RATE_W-1:0] rate, input logic [SPEED_W-1:0] speed,
                           input logic action);
    logic [CFG_DATA_W-1:0] word [5];
    logic [CFG_IDX_W-1:0]  reg_idx [5];
    reg_idx = '{CFG_MODE, CFG_LOOP, CFG_RATE, CFG_SPEED, CFG_ACTION};
    word = '{CFG_DATA_W'(mode), CFG_DATA_W'(loop_on), CFG_DATA_W'(rate),
             CFG_DATA_W'(speed), CFG_DATA_W'(action)};
    wait_drained();
    repeat (6) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx[i];
      cfg_data_i <= word[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [MODE_W-1:0]  mode_list [5];
    logic [MODE_W-1:0]  mode;
    logic               loop_on;
    logic               action;
    logic [RATE_W-1:0]  rate;
    logic [SPEED_W-1:0] speed;
    logic [OP_W-1:0]    op;
    logic [MS_W-1:0]    ms;
    logic [POS_W-1:0]   npos;
    longint unsigned    denom;
    longint unsigned    span;
    int unsigned        roll;

    mode_list = '{MODE_STATIC, MODE_NORMAL, MODE_REVERSE, MODE_PINGPONG, MODE_RPINGPONG};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_TICK;
    elapsed_ms_i = '0;
    new_position_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MODE;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no action loaded yet
    send_item(OP_TICK, 16'hFFFF, '0);
    send_item(OP_PLAY, '0, '0);
    send_item(OP_PAUSE, '0, '0);
    send_item(OP_PLAY, '0, '0);
    send_item(OP_SPARE_LO, '0, '0);
    send_item(OP_SPARE_HI, 16'hFFFF, 17'h1FFFF);
    send_item(OP_SETPOS, '0, 17'h1FFFF);
    send_item(OP_SETPOS, '0, ONE_POS);
    send_item(OP_SELECT, '0, '0);
    send_item(OP_STOP, '0, '0);

    // normal, no loop: quarter steps, run off the end, pause and resume
    configure(MODE_NORMAL, 1'b0, 24'h100000, SPEED_RST, 1'b1);
    send_item(OP_PLAY, '0, '0);
    send_item(OP_PLAY, '0, '0);
    send_item(OP_TICK, 16'd4, '0);
    send_item(OP_TICK, 16'd16, '0);
    send_item(OP_PLAY, '0, '0);
    send_item(OP_PAUSE, '0, '0);
    send_item(OP_TICK, 16'd4, '0);
    send_item(OP_PLAY, '0, '0);
    send_item(OP_STOP, '0, '0);

    // reverse looping at the largest rate and saturated speed
    configure(MODE_REVERSE, 1'b1, 24'hFFFFFF, 16'hFFFF, 1'b1);
    send_item(OP_SELECT, '0, '0);
    send_item(OP_PLAY, '0, '0);
    send_item(OP_TICK, 16'hFFFF, '0);
    send_item(OP_TICK, '0, '0);

    // ping-pong: start backward from 0 and wrap, turn at the end, then wrap again
    configure(MODE_PINGPONG, 1'b1, 24'h100000, SPEED_RST, 1'b1);
    send_item(OP_SETPOS, '0, '0);
    send_item(OP_TICK, 16'd12, '0);
    send_item(OP_TICK, 16'd12, '0);
    send_item(OP_TICK, 16'd12, '0);

    for (int k = 0; k < 13; k++) begin
      if (k < 10) mode = mode_list[k % 5];
      else if (k < 12) mode = mode_list[$urandom_range(1, 4)];
      else mode = MODE_SPARE;
      loop_on = (k < 10) ? (k >= 5) : 1'($urandom);
      action = (k != 11);
      rate = RATE_W'($urandom) >> $urandom_range(0, 16);
      speed = ($urandom_range(0, 3) == 0) ? SPEED_W'($urandom)
                                          : SPEED_W'($urandom_range(1024, 16384));
      if (k == 2) begin
        rate = 24'hFFFFFF;
        speed = 16'hFFFF;
      end else if (k == 8) begin
        rate = 24'hFFFFFF;
        speed = SPEED_MAX;
      end else if (k == 10) begin
        rate = '0;
        speed = '0;
      end
      configure(mode, loop_on, rate, speed, action);

      // elapsed time scaled so that a tick moves a useful fraction of a pass
      denom = longint'(rate) * ((speed > SPEED_MAX) ? longint'(SPEED_MAX) : longint'(speed));
      span = (denom == 0) ? 65535 : (64'd1 << 35) / denom;
      span = span * 2;
      if (span > 65535) span = 65535;
      if (span < 1) span = 1;

      calm = (k % 4 == 1);
      for (int n = 0; n < 50; n++) begin
        if (k == 4 && n == 25) wait_drained();
        roll = $urandom_range(0, 99);
        ms = MS_W'($urandom);
        npos = POS_W'($urandom);
        if (roll < 60) begin
          op = OP_TICK;
          roll = $urandom_range(0, 9);
          if (roll < 8) ms = MS_W'($urandom_range(0, int'(span)));
          else if (roll == 9) ms = '0;
        end else if (roll < 72) op = OP_PLAY;
        else if (roll < 79) op = OP_PAUSE;
        else if (roll < 83) op = OP_STOP;
        else if (roll < 91) begin
          op = OP_SETPOS;
          if ($urandom_range(0, 3) != 0) npos = POS_W'($urandom_range(0, 65536));
        end else if (roll < 96) op = OP_SELECT;
        else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        send_item(op, ms, npos);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (faults == 0 && awaiting == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
